### hdl/mhbl_pkg.sv
package mhbl_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned COUNT_W = 12;
  localparam int unsigned PCOUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_HOP_LIMIT = 1'b0;
  localparam logic REG_POINT_COUNT = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0]  hop_limit;
    logic [PCOUNT_W-1:0] point_count;
    logic                wr_limit;
    logic                wr_count;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_B_CI,
    S_B_CAP,
    S_FW_RD,
    S_FW_CMP,
    S_BW_RD,
    S_BW_CMP,
    S_B0_WR,
    S_D_RD1,
    S_D_RD2,
    S_D_WR,
    S_Q_RD,
    S_Q_CMP,
    S_Q_FIN,
    S_Q_END,
    S_RES
  } state_t;

endpackage

### hdl/mhbl_if.sv
interface mhbl_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [mhbl_pkg::COORD_W-1:0]  coordinate;
  logic [mhbl_pkg::IDX_W-1:0]    from_index;
  logic [mhbl_pkg::IDX_W-1:0]    to_index;

  modport source (output valid, op, coordinate, from_index, to_index, input ready);
  modport sink (input valid, op, coordinate, from_index, to_index, output ready);
endinterface

interface mhbl_out_if;
  logic                          valid;
  logic                          ready;
  logic [mhbl_pkg::COUNT_W-1:0]  hop_count;
  logic                          unreachable;

  modport source (output valid, hop_count, unreachable, input ready);
  modport sink (input valid, hop_count, unreachable, output ready);
endinterface

### hdl/mhbl_cfg.sv
module mhbl_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output mhbl_pkg::cfg_t       cfg
);

  logic [mhbl_pkg::COORD_W-1:0]  hop_limit;
  logic [mhbl_pkg::PCOUNT_W-1:0] point_count;
  logic                          wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_limit <= '0;
      point_count <= mhbl_pkg::PCOUNT_W'(1);
    end else if (wr) begin
      if (paddr[2] == mhbl_pkg::REG_HOP_LIMIT) begin
        hop_limit <= pwdata;
      end else begin
        point_count <= pwdata[mhbl_pkg::PCOUNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == mhbl_pkg::REG_HOP_LIMIT) begin
      prdata = hop_limit;
    end else begin
      prdata = {{(32 - mhbl_pkg::PCOUNT_W){1'b0}}, point_count};
    end
  end

  always_comb begin
    cfg.hop_limit = hop_limit;
    cfg.point_count = point_count;
    cfg.wr_limit = wr && (paddr[2] == mhbl_pkg::REG_HOP_LIMIT);
    cfg.wr_count = wr && (paddr[2] == mhbl_pkg::REG_POINT_COUNT);
  end

endmodule

### hdl/mhbl_core.sv
module mhbl_core #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned LEVELS = 11
) (
  input  logic            clk,
  input  logic            rst,
  input  mhbl_pkg::cfg_t  cfg,
  mhbl_in_if.sink         in_ch,
  mhbl_out_if.source      out_ch
);

  localparam int unsigned IW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned LW = $clog2(LEVELS + 1);
  localparam int unsigned TD = LEVELS * MAX_POINTS;
  localparam int unsigned AW = $clog2(TD);
  localparam int unsigned CNW = LEVELS + 1;
  localparam int unsigned MW = (CNW > 13) ? CNW : 13;
  localparam int unsigned QW = (CW > mhbl_pkg::IDX_W) ? CW : mhbl_pkg::IDX_W;
  localparam int unsigned PW = (CW > mhbl_pkg::PCOUNT_W) ? CW : mhbl_pkg::PCOUNT_W;

  function automatic logic [AW-1:0] taddr(input logic [LW-1:0] lvl, input logic [IW-1:0] ix);
    taddr = AW'(lvl) * AW'(MAX_POINTS) + AW'(ix);
  endfunction

  logic [mhbl_pkg::COORD_W-1:0] coord_mem [MAX_POINTS];
  logic [IW-1:0]                fwd_mem [TD];
  logic [IW-1:0]                bwd_mem [TD];

  mhbl_pkg::state_t state, state_next;

  logic [CW-1:0]  lc;
  logic           tbl_ready;
  logic [CW-1:0]  idx;
  logic [IW-1:0]  fj;
  logic [IW-1:0]  bj;
  logic [mhbl_pkg::COORD_W-1:0] ci;
  logic [LW-1:0]  k;
  logic [IW-1:0]  pos;
  logic [IW-1:0]  tgt;
  logic           fwd;
  logic [CNW-1:0] cnt;
  logic [mhbl_pkg::COUNT_W-1:0] res_cnt;
  logic           res_unr;
  logic           out_valid;
  logic [mhbl_pkg::COUNT_W-1:0] out_cnt;
  logic           out_unr;

  logic [mhbl_pkg::COORD_W-1:0] c_rd;
  logic [IW-1:0]  f_rd;
  logic [IW-1:0]  b_rd;
  logic [IW-1:0]  c_raddr;
  logic [AW-1:0]  f_raddr;
  logic [AW-1:0]  b_raddr;
  logic           t_we;
  logic [AW-1:0]  t_waddr;
  logic [IW-1:0]  f_wdata;
  logic [IW-1:0]  b_wdata;

  logic [CW-1:0]  n;
  logic           loaded;
  logic           acc;
  logic           load_ok;
  logic           q_bad;
  logic [QW-1:0]  from_q;
  logic [QW-1:0]  to_q;
  logic           out_free;
  logic [IW-1:0]  nx;
  logic           take;
  logic [CNW-1:0] cnt_p1;

  always_comb begin
    if (cfg.point_count == '0) begin
      n = CW'(1);
    end else if (PW'(cfg.point_count) > PW'(MAX_POINTS)) begin
      n = CW'(MAX_POINTS);
    end else begin
      n = CW'(cfg.point_count);
    end
  end

  assign loaded = lc >= n;
  assign acc = in_ch.valid && in_ch.ready;
  assign load_ok = !tbl_ready && (lc < n);
  assign from_q = QW'(in_ch.from_index);
  assign to_q = QW'(in_ch.to_index);
  assign q_bad = !tbl_ready || (from_q >= QW'(n)) || (to_q >= QW'(n));
  assign out_free = !out_valid || out_ch.ready;
  assign nx = fwd ? f_rd : b_rd;
  assign take = fwd ? (nx < tgt) : (nx > tgt);
  assign cnt_p1 = cnt + CNW'(1);

  assign in_ch.ready = (state == mhbl_pkg::S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.hop_count = out_cnt;
  assign out_ch.unreachable = out_unr;

  // Read addresses for the three memories, and write enable, address and data for the two jump tables.
  always_comb begin
    c_raddr = idx[IW-1:0];
    f_raddr = '0;
    b_raddr = '0;
    t_we = 1'b0;
    t_waddr = taddr(k, idx[IW-1:0]);
    f_wdata = f_rd;
    b_wdata = b_rd;
    unique case (state)
      mhbl_pkg::S_FW_RD: c_raddr = fj + IW'(1);
      mhbl_pkg::S_BW_RD: c_raddr = bj - IW'(1);
      mhbl_pkg::S_B0_WR: begin
        t_we = 1'b1;
        t_waddr = taddr('0, idx[IW-1:0]);
        f_wdata = fj;
        b_wdata = bj;
      end
      mhbl_pkg::S_D_RD1: begin
        f_raddr = taddr(k - LW'(1), idx[IW-1:0]);
        b_raddr = taddr(k - LW'(1), idx[IW-1:0]);
      end
      mhbl_pkg::S_D_RD2: begin
        f_raddr = taddr(k - LW'(1), f_rd);
        b_raddr = taddr(k - LW'(1), b_rd);
      end
      mhbl_pkg::S_D_WR: t_we = 1'b1;
      mhbl_pkg::S_Q_RD: begin
        f_raddr = taddr(k, pos);
        b_raddr = taddr(k, pos);
      end
      mhbl_pkg::S_Q_FIN: begin
        f_raddr = taddr('0, pos);
        b_raddr = taddr('0, pos);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    c_rd <= coord_mem[c_raddr];
    if (state == mhbl_pkg::S_IDLE && acc && in_ch.op == mhbl_pkg::OP_LOAD && load_ok) begin
      coord_mem[lc[IW-1:0]] <= in_ch.coordinate;
    end
  end

  always_ff @(posedge clk) begin
    f_rd <= fwd_mem[f_raddr];
    b_rd <= bwd_mem[b_raddr];
    if (t_we) begin
      fwd_mem[t_waddr] <= f_wdata;
      bwd_mem[t_waddr] <= b_wdata;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mhbl_pkg::S_IDLE: begin
        if (acc && in_ch.op == mhbl_pkg::OP_QUERY) begin
          state_next = q_bad ? mhbl_pkg::S_RES : mhbl_pkg::S_Q_RD;
        end else if (acc && load_ok && (lc + CW'(1) >= n)) begin
          state_next = mhbl_pkg::S_B_CI;
        end
      end
      mhbl_pkg::S_B_CI: state_next = mhbl_pkg::S_B_CAP;
      mhbl_pkg::S_B_CAP: state_next = mhbl_pkg::S_FW_RD;
      mhbl_pkg::S_FW_RD: begin
        state_next = (CW'(fj) + CW'(1) < n) ? mhbl_pkg::S_FW_CMP : mhbl_pkg::S_BW_RD;
      end
      mhbl_pkg::S_FW_CMP: begin
        state_next = ({1'b0, c_rd} <= {1'b0, ci} + {1'b0, cfg.hop_limit}) ?
                     mhbl_pkg::S_FW_RD : mhbl_pkg::S_BW_RD;
      end
      mhbl_pkg::S_BW_RD: state_next = (bj != '0) ? mhbl_pkg::S_BW_CMP : mhbl_pkg::S_B0_WR;
      mhbl_pkg::S_BW_CMP: begin
        state_next = ({1'b0, c_rd} + {1'b0, cfg.hop_limit} >= {1'b0, ci}) ?
                     mhbl_pkg::S_BW_RD : mhbl_pkg::S_B0_WR;
      end
      mhbl_pkg::S_B0_WR: begin
        if (idx + CW'(1) == n) begin
          state_next = (LEVELS > 1) ? mhbl_pkg::S_D_RD1 : mhbl_pkg::S_IDLE;
        end else begin
          state_next = mhbl_pkg::S_B_CI;
        end
      end
      mhbl_pkg::S_D_RD1: state_next = mhbl_pkg::S_D_RD2;
      mhbl_pkg::S_D_RD2: state_next = mhbl_pkg::S_D_WR;
      mhbl_pkg::S_D_WR: begin
        if (idx + CW'(1) == n && 32'(k) + 32'd1 == 32'(LEVELS)) begin
          state_next = mhbl_pkg::S_IDLE;
        end else begin
          state_next = mhbl_pkg::S_D_RD1;
        end
      end
      mhbl_pkg::S_Q_RD: state_next = mhbl_pkg::S_Q_CMP;
      mhbl_pkg::S_Q_CMP: state_next = (k == '0) ? mhbl_pkg::S_Q_FIN : mhbl_pkg::S_Q_RD;
      mhbl_pkg::S_Q_FIN: state_next = mhbl_pkg::S_Q_END;
      mhbl_pkg::S_Q_END: state_next = mhbl_pkg::S_RES;
      mhbl_pkg::S_RES: state_next = out_free ? mhbl_pkg::S_IDLE : mhbl_pkg::S_RES;
      default: state_next = mhbl_pkg::S_IDLE;
    endcase
    // A new point count abandons any build; a new limit rebuilds loaded tables.
    if (cfg.wr_count) begin
      state_next = mhbl_pkg::S_IDLE;
    end else if (cfg.wr_limit && loaded) begin
      state_next = mhbl_pkg::S_B_CI;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhbl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lc <= '0;
      tbl_ready <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == mhbl_pkg::S_RES && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.wr_count) begin
        lc <= '0;
        tbl_ready <= 1'b0;
      end else if (cfg.wr_limit && loaded) begin
        tbl_ready <= 1'b0;
      end else begin
        unique case (state)
          mhbl_pkg::S_IDLE: begin
            if (acc && in_ch.op == mhbl_pkg::OP_LOAD && load_ok) begin
              lc <= lc + CW'(1);
            end
          end
          mhbl_pkg::S_B0_WR: begin
            if (idx + CW'(1) == n && LEVELS == 1) begin
              tbl_ready <= 1'b1;
            end
          end
          mhbl_pkg::S_D_WR: begin
            if (idx + CW'(1) == n && 32'(k) + 32'd1 == 32'(LEVELS)) begin
              tbl_ready <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((cfg.wr_limit && loaded) ||
        (state == mhbl_pkg::S_IDLE && acc && in_ch.op == mhbl_pkg::OP_LOAD)) begin
      idx <= '0;
    end else begin
      unique case (state)
        mhbl_pkg::S_IDLE: begin
          if (acc && in_ch.op == mhbl_pkg::OP_QUERY) begin
            pos <= from_q[IW-1:0];
            tgt <= to_q[IW-1:0];
            fwd <= from_q < to_q;
            k <= LW'(LEVELS - 1);
            cnt <= '0;
            res_cnt <= mhbl_pkg::COUNT_MAX;
            res_unr <= 1'b1;
          end
        end
        mhbl_pkg::S_B_CAP: begin
          ci <= c_rd;
          fj <= idx[IW-1:0];
          bj <= idx[IW-1:0];
        end
        mhbl_pkg::S_FW_CMP: begin
          if ({1'b0, c_rd} <= {1'b0, ci} + {1'b0, cfg.hop_limit}) begin
            fj <= fj + IW'(1);
          end
        end
        mhbl_pkg::S_BW_CMP: begin
          if ({1'b0, c_rd} + {1'b0, cfg.hop_limit} >= {1'b0, ci}) begin
            bj <= bj - IW'(1);
          end
        end
        mhbl_pkg::S_B0_WR: begin
          if (idx + CW'(1) == n) begin
            idx <= '0;
            k <= LW'(1);
          end else begin
            idx <= idx + CW'(1);
          end
        end
        mhbl_pkg::S_D_WR: begin
          if (idx + CW'(1) == n) begin
            idx <= '0;
            k <= k + LW'(1);
          end else begin
            idx <= idx + CW'(1);
          end
        end
        mhbl_pkg::S_Q_CMP: begin
          if (take) begin
            pos <= nx;
            cnt <= cnt | (CNW'(1) << k);
          end
          if (k != '0) begin
            k <= k - LW'(1);
          end
        end
        mhbl_pkg::S_Q_END: begin
          if (fwd ? (nx >= tgt) : (nx <= tgt)) begin
            res_unr <= 1'b0;
            res_cnt <= (MW'(cnt_p1) > MW'(mhbl_pkg::COUNT_MAX)) ?
                       mhbl_pkg::COUNT_MAX : mhbl_pkg::COUNT_W'(cnt_p1);
          end
        end
        mhbl_pkg::S_RES: begin
          if (out_free) begin
            out_cnt <= res_cnt;
            out_unr <= res_unr;
          end
        end
        default: ;
      endcase
    end
  end

  a_ready_loaded: assert property (@(posedge clk) disable iff (rst)
    tbl_ready |-> (lc >= n))
    else $error("tables marked ready before all points were loaded");

  a_fw_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == mhbl_pkg::S_FW_CMP) |-> (CW'(fj) + CW'(1) < n))
    else $error("forward scan ran past the last point");

  a_query_only_ready: assert property (@(posedge clk) disable iff (rst)
    (state == mhbl_pkg::S_Q_RD) |-> tbl_ready)
    else $error("lifting walk started without built tables");

endmodule

### hdl/min_hop_count_binary_lifting.sv
// Channel   Dir   Payload                                   Transaction when
// in_ch     in    op, coordinate, from_index, to_index      valid && ready
// out_ch    out   hop_count, unreachable                    valid && ready
// apb       in    paddr, pwdata (hop_limit, point_count)    psel && penable && pwrite
//
// A query reads a jump table memory and compares once per level, from the highest
// level down, then reads level 0 to decide. The final load starts the table build:
// level 0 by scanning neighbouring coordinates of each point forward and backward,
// then each higher level by doubling, all through the single read port of each
// memory. No item is taken during the build. Reset idles the controller, clears the
// load count and the ready and output valid flags and resets the configuration
// registers. A stalled result waits in the output register; the next item is taken
// meanwhile.
module min_hop_count_binary_lifting #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned LEVELS = 11
) (
  input  logic        clk,
  input  logic        rst,
  mhbl_in_if.sink     in_ch,
  mhbl_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mhbl_pkg::cfg_t cfg;

  mhbl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mhbl_core #(
    .MAX_POINTS (MAX_POINTS),
    .LEVELS     (LEVELS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

### tb/tb_min_hop_count_binary_lifting.sv
module tb_min_hop_count_binary_lifting;

  localparam int NPTS = 1024;
  localparam int NLEV = 11;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic                          op;
    logic [mhbl_pkg::COORD_W-1:0]  coordinate;
    logic [mhbl_pkg::IDX_W-1:0]    from_index;
    logic [mhbl_pkg::IDX_W-1:0]    to_index;
  } hop_item_t;

  typedef struct {
    logic [mhbl_pkg::COUNT_W-1:0] hop_count;
    logic                         unreachable;
  } hop_answer_t;

  typedef enum int {CO_ASCENDING, CO_SCRAMBLED, CO_EXTREMES} coord_mode_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mhbl_in_if  in_ch ();
  mhbl_out_if out_ch ();

  min_hop_count_binary_lifting uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state.
  logic [mhbl_pkg::COORD_W-1:0]  span_lim;
  logic [mhbl_pkg::PCOUNT_W-1:0] pts_cfg;
  int                            loaded;
  bit                            tables_built;
  logic [mhbl_pkg::COORD_W-1:0]  point_pos [NPTS];
  logic [mhbl_pkg::IDX_W-1:0]    fwd_jump [NLEV][NPTS];
  logic [mhbl_pkg::IDX_W-1:0]    bwd_jump [NLEV][NPTS];

  hop_item_t   pending_items [$];
  hop_answer_t awaited_hops [$];

  int     errors;
  int     n_loads;
  int     n_queries;
  int     n_answers;
  longint cycles;
  bit     in_fire;
  bit     no_gaps;
  bit     backlog_go;
  bit     backlog_done;
  int     backlog_left;
  int     in_gap;
  int     out_gap;

  function automatic int live_points();
    if (int'(pts_cfg) < 1) return 1;
    if (int'(pts_cfg) > NPTS) return NPTS;
    return int'(pts_cfg);
  endfunction

  function automatic void build_jumps();
    int n;
    int j;
    logic [mhbl_pkg::COORD_W:0] reach;
    n = live_points();
    for (int i = 0; i < n; i++) begin
      reach = {1'b0, point_pos[i]} + {1'b0, span_lim};
      j = i;
      while (j + 1 < n && {1'b0, point_pos[j+1]} <= reach) j++;
      fwd_jump[0][i] = mhbl_pkg::IDX_W'(j);
      j = i;
      while (j > 0 && {1'b0, point_pos[j-1]} + {1'b0, span_lim} >= {1'b0, point_pos[i]}) j--;
      bwd_jump[0][i] = mhbl_pkg::IDX_W'(j);
    end
    for (int k = 1; k < NLEV; k++) begin
      for (int i = 0; i < n; i++) begin
        fwd_jump[k][i] = fwd_jump[k-1][fwd_jump[k-1][i]];
        bwd_jump[k][i] = bwd_jump[k-1][bwd_jump[k-1][i]];
      end
    end
    tables_built = 1;
  endfunction

  function automatic void apply_reg(logic idx, logic [31:0] value);
    if (idx == mhbl_pkg::REG_HOP_LIMIT) begin
      span_lim = value;
      if (tables_built) build_jumps();
    end else begin
      pts_cfg = value[mhbl_pkg::PCOUNT_W-1:0];
      loaded = 0;
      tables_built = 0;
    end
  endfunction

  // Returns 1 when the item yields an answer.
  function automatic bit predict_hops(hop_item_t it, output hop_answer_t ans);
    int n;
    int pos;
    int src;
    int dst;
    longint cnt;
    bit ok;
    n = live_points();
    ans.hop_count = mhbl_pkg::COUNT_MAX;
    ans.unreachable = 1;
    if (it.op == mhbl_pkg::OP_LOAD) begin
      if (!tables_built && loaded < n) begin
        point_pos[loaded] = it.coordinate;
        loaded++;
        if (loaded >= n) build_jumps();
      end
      return 0;
    end
    src = int'(it.from_index);
    dst = int'(it.to_index);
    if (!tables_built || src >= n || dst >= n) return 1;
    pos = src;
    cnt = 0;
    if (src < dst) begin
      for (int k = NLEV - 1; k >= 0; k--) begin
        if (int'(fwd_jump[k][pos]) < dst) begin
          pos = int'(fwd_jump[k][pos]);
          cnt += longint'(1) << k;
        end
      end
      ok = int'(fwd_jump[0][pos]) >= dst;
    end else begin
      for (int k = NLEV - 1; k >= 0; k--) begin
        if (int'(bwd_jump[k][pos]) > dst) begin
          pos = int'(bwd_jump[k][pos]);
          cnt += longint'(1) << k;
        end
      end
      ok = int'(bwd_jump[0][pos]) <= dst;
    end
    if (ok) begin
      cnt += 1;
      ans.hop_count = (cnt > longint'(mhbl_pkg::COUNT_MAX)) ? mhbl_pkg::COUNT_MAX :
                      cnt[mhbl_pkg::COUNT_W-1:0];
      ans.unreachable = 0;
    end
    return 1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Input driver: changes at the falling edge.
  always @(negedge clk) begin
    hop_item_t it;
    if (!in_ch.valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_ch.op <= it.op;
        in_ch.coordinate <= it.coordinate;
        in_ch.from_index <= it.from_index;
        in_ch.to_index <= it.to_index;
        in_ch.valid <= 1;
        in_gap <= pick_gap();
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // Result receiver, including the long hold-off that lets the block back up.
  // The hold-off starts on a result from built tables, so that queries keep coming.
  always @(negedge clk) begin
    if (backlog_go && !backlog_done && backlog_left == 0 && out_ch.valid && tables_built) begin
      backlog_left <= 400;
      backlog_done <= 1;
      out_ch.ready <= 0;
    end else if (backlog_left > 0) begin
      backlog_left <= backlog_left - 1;
      out_ch.ready <= 0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= 1;
      out_gap <= pick_gap();
    end
  end

  // Monitor: samples both channels at the rising edge.
  always @(posedge clk) begin
    hop_item_t   it;
    hop_answer_t ans;
    hop_answer_t want;
    in_fire <= in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      it.op = in_ch.op;
      it.coordinate = in_ch.coordinate;
      it.from_index = in_ch.from_index;
      it.to_index = in_ch.to_index;
      if (it.op == mhbl_pkg::OP_LOAD) n_loads++;
      else n_queries++;
      if (predict_hops(it, ans)) awaited_hops.push_back(ans);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_answers++;
      if (awaited_hops.size() == 0) begin
        errors++;
        $display("%0t: unexpected result hop_count=%0d unreachable=%0b", $time,
                 out_ch.hop_count, out_ch.unreachable);
      end else begin
        want = awaited_hops.pop_front();
        if (out_ch.hop_count !== want.hop_count) begin
          errors++;
          $display("%0t: hop_count expected %0d actual %0d", $time, want.hop_count,
                   out_ch.hop_count);
        end
        if (out_ch.unreachable !== want.unreachable) begin
          errors++;
          $display("%0t: unreachable expected %0b actual %0b", $time, want.unreachable,
                   out_ch.unreachable);
        end
      end
    end
  end

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    apply_reg(idx, value);
  endtask

  task automatic push_item(logic op, logic [31:0] c, int f, int t);
    hop_item_t it;
    it.op = op;
    it.coordinate = c;
    it.from_index = mhbl_pkg::IDX_W'(f);
    it.to_index = mhbl_pkg::IDX_W'(t);
    pending_items.push_back(it);
  endtask

  // Each batch ends in a query, so its answer means the block is idle again.
  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || awaited_hops.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic push_queries(int n, int nq);
    for (int q = 0; q < nq; q++) begin
      if ($urandom_range(0, 9) == 0)
        push_item(mhbl_pkg::OP_LOAD, $urandom, $urandom_range(0, 1023),
                  $urandom_range(0, 1023));
      else if ($urandom_range(0, 4) == 0)
        push_item(mhbl_pkg::OP_QUERY, $urandom, $urandom_range(0, 1023),
                  $urandom_range(0, 1023));
      else
        push_item(mhbl_pkg::OP_QUERY, $urandom, $urandom_range(0, n - 1),
                  $urandom_range(0, n - 1));
    end
    push_item(mhbl_pkg::OP_QUERY, 0, 0, n - 1);
  endtask

  task automatic run_phase(int pc, logic [31:0] lim, coord_mode_t mode, int step_max,
                           int nq, logic [31:0] lim2);
    int n;
    logic [31:0] c;
    write_reg(mhbl_pkg::REG_POINT_COUNT, 32'(pc));
    write_reg(mhbl_pkg::REG_HOP_LIMIT, lim);
    n = live_points();
    c = $urandom_range(0, 1000);
    for (int i = 0; i < n; i++) begin
      case (mode)
        CO_ASCENDING: c = c + $urandom_range(0, step_max);
        CO_SCRAMBLED: c = $urandom;
        default:      c = (i < n / 2) ? 32'h0 : 32'hFFFF_FFFF;
      endcase
      // Queries before the tables are complete see no tables.
      if ($urandom_range(0, 19) == 0)
        push_item(mhbl_pkg::OP_QUERY, $urandom, $urandom_range(0, n - 1),
                  $urandom_range(0, n - 1));
      push_item(mhbl_pkg::OP_LOAD, c, $urandom_range(0, 1023), $urandom_range(0, 1023));
    end
    push_queries(n, nq);
    drain();
    // A new limit on built tables forces a rebuild.
    write_reg(mhbl_pkg::REG_HOP_LIMIT, lim2);
    push_queries(n, nq / 2);
    drain();
  endtask

  initial begin
    int n;
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    in_ch.valid = 0;
    in_ch.op = mhbl_pkg::OP_LOAD;
    in_ch.coordinate = 0;
    in_ch.from_index = 0;
    in_ch.to_index = 0;
    out_ch.ready = 0;
    span_lim = 0;
    pts_cfg = 1;
    loaded = 0;
    tables_built = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: queries before any load, then a single point.
    push_item(mhbl_pkg::OP_QUERY, 0, 0, 0);
    push_item(mhbl_pkg::OP_QUERY, 32'hFFFF_FFFF, 1023, 1023);
    drain();
    write_reg(mhbl_pkg::REG_POINT_COUNT, 32'd0);
    write_reg(mhbl_pkg::REG_HOP_LIMIT, 32'd0);
    push_item(mhbl_pkg::OP_LOAD, 32'hFFFF_FFFF, 0, 0);
    push_item(mhbl_pkg::OP_LOAD, 5, 0, 0);
    push_item(mhbl_pkg::OP_QUERY, 0, 0, 0);
    push_item(mhbl_pkg::OP_QUERY, 0, 0, 1);
    push_item(mhbl_pkg::OP_QUERY, 0, 1023, 0);
    drain();

    run_phase(4, 32'hFFFF_FFFF, CO_EXTREMES, 0, 12, 32'h0);
    run_phase(16, 10, CO_ASCENDING, 8, 20, 0);
    run_phase(6, 32'hFFFF_FFFE, CO_ASCENDING, 3, 12, 1);

    // A larger set with short hops; the receiver stalls to back the block up.
    backlog_go = 1;
    run_phase(120, 60, CO_ASCENDING, 40, 40, 25);
    run_phase(12, $urandom, CO_SCRAMBLED, 0, 20, $urandom);

    while (n_loads + n_queries < 440) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(2, 30);
      if ($urandom_range(0, 1))
        run_phase(n, $urandom_range(0, 20), CO_ASCENDING, 10, 30, $urandom_range(0, 40));
      else
        run_phase(n, $urandom, CO_SCRAMBLED, 0, 30, $urandom);
    end

    repeat (200) @(posedge clk);
    $display("ran %0d loads and %0d queries, %0d results checked, %0d errors",
             n_loads, n_queries, n_answers, errors);
    $display("covered clamped point counts, hop limits from 0 to max, rebuilds and backlog");
    if (errors == 0 && awaited_hops.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
